FILE: rtl/core/pyramid_temporal_iir_magnifier_defines.svh
// assertion macros shared by the core modules
`ifndef PYRAMID_TEMPORAL_IIR_MAGNIFIER_DEFINES_SVH
`define PYRAMID_TEMPORAL_IIR_MAGNIFIER_DEFINES_SVH

// condition checked at every clock edge out of reset
`define PTIM_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define PTIM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PTIM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/ptim_pkg.sv
`timescale 1ns / 1ps
package ptim_pkg;

	localparam int VAL_W  = 16;
	localparam int ADDR_W = 16;
	localparam int LVL_W  = 3;
	localparam int CHAN_W = 2;
	localparam int PAR_W  = 16;
	localparam int LAM_W  = 24;
	localparam int CFG_W  = 24;
	localparam int CFG_IDX_W = 3;
	localparam int GAIN_W = 18;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHA     = 3'd0,
		REG_RATE_FAST = 3'd1,
		REG_RATE_SLOW = 3'd2,
		REG_CHROMA    = 3'd3,
		REG_LAMBDA    = 3'd4
	} reg_idx_t;

	localparam logic [CHAN_W-1:0] CHAN_CB = 2'd1;
	localparam logic [CHAN_W-1:0] CHAN_CR = 2'd2;

	localparam logic [PAR_W-1:0] ALPHA_RST     = 16'd2560;
	localparam logic [PAR_W-1:0] RATE_FAST_RST = 16'd26214;
	localparam logic [PAR_W-1:0] RATE_SLOW_RST = 16'd3277;
	localparam logic [PAR_W-1:0] CHROMA_RST    = 16'd6554;
	localparam logic [LAM_W-1:0] LAMBDA_RST    = 24'd0;

	typedef struct packed {
		logic [PAR_W-1:0] alpha;
		logic [PAR_W-1:0] rate_fast;
		logic [PAR_W-1:0] rate_slow;
		logic [PAR_W-1:0] chroma_scale;
		logic [LAM_W-1:0] lambda_ratio;
	} cfg_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [ADDR_W-1:0]       addr;
		logic [LVL_W-1:0]        level;
		logic                    chroma;
		logic                    fend;
	} coef_t;

	typedef struct packed {
		logic                     primed;
		logic signed [VAL_W-1:0]  value;
		logic signed [VAL_W-1:0]  fast;
		logic signed [VAL_W-1:0]  slow;
		logic signed [GAIN_W-1:0] gain;
		logic                     chroma;
		logic [ADDR_W-1:0]        addr;
		logic                     fend;
	} lp_res_t;

endpackage

FILE: rtl/core/pyramid_temporal_iir_magnifier.sv
`timescale 1ns / 1ps
// registered steps from input transfer to result valid: index, read, lowpass, gain, chroma, saturate
// throughput: one coefficient per cycle unless out_stall holds; filter state read and written back
// once per item, same-address back-to-back items served by a one-entry bypass
// the whole pipeline holds while a result waits under out_stall
// reset: pipeline valids and primed flag cleared, registers to defaults; filter memories not
// cleared, the first frame loads them
module pyramid_temporal_iir_magnifier import ptim_pkg::*; #(
	parameter int LEVELS      = 6,
	parameter int COEFF_DEPTH = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [VAL_W-1:0]     coeff_value,
	input  logic [ADDR_W-1:0]    coeff_addr,
	input  logic [LVL_W-1:0]     level_index,
	input  logic [CHAN_W-1:0]    chan_index,
	input  logic                 frame_end,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [VAL_W-1:0]     amplified_value,
	output logic [ADDR_W-1:0]    out_addr,
	output logic                 out_frame_end
);

	localparam int IDX_W = $clog2(COEFF_DEPTH);

	cfg_t             cfg_q;
	logic             adv;
	logic             in_accept;
	coef_t            in_coef;
	logic             item_valid;
	coef_t            item;
	logic [IDX_W-1:0] item_idx;
	logic             res_valid;
	lp_res_t          res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha        <= ALPHA_RST;
			cfg_q.rate_fast    <= RATE_FAST_RST;
			cfg_q.rate_slow    <= RATE_SLOW_RST;
			cfg_q.chroma_scale <= CHROMA_RST;
			cfg_q.lambda_ratio <= LAMBDA_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_ALPHA:     cfg_q.alpha        <= cfg_data[PAR_W-1:0];
				REG_RATE_FAST: cfg_q.rate_fast    <= cfg_data[PAR_W-1:0];
				REG_RATE_SLOW: cfg_q.rate_slow    <= cfg_data[PAR_W-1:0];
				REG_CHROMA:    cfg_q.chroma_scale <= cfg_data[PAR_W-1:0];
				REG_LAMBDA:    cfg_q.lambda_ratio <= cfg_data[LAM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall  = !adv;
	assign in_accept = in_valid && adv;

	assign in_coef.value  = $signed(coeff_value);
	assign in_coef.addr   = coeff_addr;
	assign in_coef.level  = level_index;
	assign in_coef.chroma = (chan_index == CHAN_CB) || (chan_index == CHAN_CR);
	assign in_coef.fend   = frame_end;

	ptim_index #(.COEFF_DEPTH(COEFF_DEPTH)) u_index (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_accept  (in_accept),
		.in_coef    (in_coef),
		.item_valid (item_valid),
		.item       (item),
		.item_idx   (item_idx)
	);

	ptim_lowpass #(.LEVELS(LEVELS), .COEFF_DEPTH(COEFF_DEPTH)) u_lowpass (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg_q),
		.in_valid  (item_valid),
		.in_item   (item),
		.in_idx    (item_idx),
		.res_valid (res_valid),
		.res       (res)
	);

	ptim_scale u_scale (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.in_valid        (res_valid),
		.in_res          (res),
		.out_stall       (out_stall),
		.adv             (adv),
		.out_valid       (out_valid),
		.amplified_value (amplified_value),
		.out_addr        (out_addr),
		.out_frame_end   (out_frame_end)
	);

endmodule

FILE: rtl/core/ptim_ram.sv
`timescale 1ns / 1ps
module ptim_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/ptim_index.sv
`timescale 1ns / 1ps
`include "pyramid_temporal_iir_magnifier_defines.svh"
module ptim_index import ptim_pkg::*; #(
	parameter int COEFF_DEPTH = 65536
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic                           in_accept,
	input  coef_t                          in_coef,
	output logic                           item_valid,
	output coef_t                          item,
	output logic [$clog2(COEFF_DEPTH)-1:0] item_idx
);

	localparam int IDX_W   = $clog2(COEFF_DEPTH);
	localparam int RECIP_W = 25;
	localparam int PROD_W  = ADDR_W + RECIP_W;
	localparam int QUOT_W  = PROD_W - 32;
	localparam int REM_W   = ADDR_W + 1;
	localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << 32) / COEFF_DEPTH);
	localparam logic [REM_W-1:0]   DEPTH_C = REM_W'(COEFF_DEPTH);

	logic              valid_s1;
	coef_t             coef_s1;
	logic              valid_s2;
	coef_t             coef_s2;
	logic [QUOT_W-1:0] quot_s2;

	logic [PROD_W-1:0]       prod;
	logic [QUOT_W+REM_W-1:0] qd;
	logic [REM_W-1:0]        rem;
	logic [REM_W-1:0]        rem_fix;

	// quotient estimate is exact or one low
	assign prod    = PROD_W'(coef_s1.addr) * PROD_W'(RECIP);
	assign qd      = (QUOT_W+REM_W)'(quot_s2) * (QUOT_W+REM_W)'(DEPTH_C);
	assign rem     = {1'b0, coef_s2.addr} - qd[REM_W-1:0];
	assign rem_fix = (rem >= DEPTH_C) ? (rem - DEPTH_C) : rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coef_s1 <= in_coef;
			coef_s2 <= coef_s1;
			quot_s2 <= prod[PROD_W-1:32];
		end
	end

	assign item_valid = valid_s2;
	assign item       = coef_s2;
	assign item_idx   = rem_fix[IDX_W-1:0];

	`PTIM_ASSERT_IMPL(a_idx_range, valid_s2, rem_fix < DEPTH_C, "memory index out of range")

endmodule

FILE: rtl/core/ptim_lowpass.sv
`timescale 1ns / 1ps
`include "pyramid_temporal_iir_magnifier_defines.svh"
module ptim_lowpass import ptim_pkg::*; #(
	parameter int LEVELS      = 6,
	parameter int COEFF_DEPTH = 65536
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  cfg_t                           cfg,
	input  logic                           in_valid,
	input  coef_t                          in_item,
	input  logic [$clog2(COEFF_DEPTH)-1:0] in_idx,
	output logic                           res_valid,
	output lp_res_t                        res
);

	localparam int IDX_W = $clog2(COEFF_DEPTH);

	function automatic logic signed [VAL_W-1:0] lp_update(
		input logic signed [VAL_W-1:0] lp,
		input logic signed [VAL_W-1:0] x,
		input logic [PAR_W-1:0]        rate
	);
		logic signed [VAL_W:0]     diff;
		logic signed [2*VAL_W+1:0] prod;
		logic signed [VAL_W+1:0]   step;
		logic signed [VAL_W+1:0]   sum;
		diff = $signed({x[VAL_W-1], x}) - $signed({lp[VAL_W-1], lp});
		prod = $signed({1'b0, rate}) * diff;
		step = (VAL_W+2)'((prod + 34'sd32768) >>> 16);
		sum  = $signed({{2{lp[VAL_W-1]}}, lp}) + step;
		return sum[VAL_W-1:0];
	endfunction

	function automatic logic signed [GAIN_W-1:0] level_gain(
		input logic [LVL_W-1:0] lvl,
		input logic [LAM_W-1:0] lambda,
		input logic [PAR_W-1:0] alpha
	);
		logic [LVL_W-1:0]        shamt;
		logic [LAM_W:0]          shifted;
		logic signed [LAM_W+1:0] c;
		logic signed [GAIN_W-1:0] g;
		shamt   = LVL_W'(LEVELS) - lvl;
		shifted = {lambda, 1'b0} >> shamt;
		c       = $signed({1'b0, shifted}) - 26'sd512;
		if (lvl == '0 || lvl >= LVL_W'(LEVELS)) begin
			g = '0;
		end else if (c > $signed({10'b0, alpha})) begin
			g = $signed({2'b0, alpha});
		end else begin
			g = c[GAIN_W-1:0];
		end
		return g;
	endfunction

	logic             valid_s3;
	coef_t            coef_s3;
	logic [IDX_W-1:0] idx_s3;
	logic             valid_s4;
	lp_res_t          res_s4;
	logic [IDX_W-1:0] idx_s4;
	logic             primed_q;

	logic [VAL_W-1:0]        rd_fast;
	logic [VAL_W-1:0]        rd_slow;
	logic                    fwd_hit;
	logic signed [VAL_W-1:0] lp_fast;
	logic signed [VAL_W-1:0] lp_slow;
	logic signed [VAL_W-1:0] new_fast;
	logic signed [VAL_W-1:0] new_slow;
	logic                    rd_en;
	logic                    wr_en;

	assign rd_en = adv & in_valid;
	assign wr_en = adv & valid_s3;

	ptim_ram #(.WIDTH(VAL_W), .DEPTH(COEFF_DEPTH)) u_fast_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_s3),
		.wdata (new_fast),
		.re    (rd_en),
		.raddr (in_idx),
		.rdata (rd_fast)
	);

	ptim_ram #(.WIDTH(VAL_W), .DEPTH(COEFF_DEPTH)) u_slow_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_s3),
		.wdata (new_slow),
		.re    (rd_en),
		.raddr (in_idx),
		.rdata (rd_slow)
	);

	// the item one stage ahead wrote on the same edge as this read
	assign fwd_hit = valid_s4 && (idx_s4 == idx_s3);
	assign lp_fast = fwd_hit ? res_s4.fast : $signed(rd_fast);
	assign lp_slow = fwd_hit ? res_s4.slow : $signed(rd_slow);

	always_comb begin
		if (primed_q) begin
			new_fast = lp_update(lp_fast, coef_s3.value, cfg.rate_fast);
			new_slow = lp_update(lp_slow, coef_s3.value, cfg.rate_slow);
		end else begin
			new_fast = coef_s3.value;
			new_slow = coef_s3.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			primed_q <= 1'b0;
		end else if (adv) begin
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
			if (valid_s3 && !primed_q && coef_s3.fend) begin
				primed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coef_s3       <= in_item;
			idx_s3        <= in_idx;
			idx_s4        <= idx_s3;
			res_s4.primed <= primed_q;
			res_s4.value  <= coef_s3.value;
			res_s4.fast   <= new_fast;
			res_s4.slow   <= new_slow;
			res_s4.gain   <= level_gain(coef_s3.level, cfg.lambda_ratio, cfg.alpha);
			res_s4.chroma <= coef_s3.chroma;
			res_s4.addr   <= coef_s3.addr;
			res_s4.fend   <= coef_s3.fend;
		end
	end

	assign res_valid = valid_s4;
	assign res       = res_s4;

	`PTIM_ASSERT_ALWAYS(a_primed_sticky, !$fell(primed_q), "primed flag cleared outside reset")
	`PTIM_ASSERT_IMPL(a_fast_bound, valid_s3 && primed_q, (new_fast >= lp_fast && new_fast <= coef_s3.value) || (new_fast <= lp_fast && new_fast >= coef_s3.value), "fast lowpass left its bounds")
	`PTIM_ASSERT_IMPL(a_slow_bound, valid_s3 && primed_q, (new_slow >= lp_slow && new_slow <= coef_s3.value) || (new_slow <= lp_slow && new_slow >= coef_s3.value), "slow lowpass left its bounds")

endmodule

FILE: rtl/core/ptim_scale.sv
`timescale 1ns / 1ps
`include "pyramid_temporal_iir_magnifier_defines.svh"
module ptim_scale import ptim_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	input  lp_res_t           in_res,
	input  logic              out_stall,
	output logic              adv,
	output logic              out_valid,
	output logic [VAL_W-1:0]  amplified_value,
	output logic [ADDR_W-1:0] out_addr,
	output logic              out_frame_end
);

	localparam int BAND_W = VAL_W + 1;
	localparam int BP_W   = BAND_W + GAIN_W;
	localparam int AMP_W  = BP_W - 8;
	localparam int CP_W   = AMP_W + PAR_W + 1;
	localparam int CHR_W  = CP_W - 16;

	logic                    valid_s5;
	logic signed [AMP_W-1:0] val_s5;
	logic                    chroma_s5;
	logic [ADDR_W-1:0]       addr_s5;
	logic                    fend_s5;
	logic                    valid_s6;
	logic signed [CHR_W-1:0] val_s6;
	logic [ADDR_W-1:0]       addr_s6;
	logic                    fend_s6;
	logic                    out_valid_q;
	logic [VAL_W-1:0]        amp_q;
	logic [ADDR_W-1:0]       addr_q;
	logic                    fend_q;

	logic signed [BAND_W-1:0] band;
	logic signed [BP_W-1:0]   bprod;
	logic signed [AMP_W-1:0]  amp;
	logic signed [CP_W-1:0]   cprod;
	logic signed [CHR_W-1:0]  chr;
	logic [VAL_W-1:0]         sat;

	assign adv = !out_valid_q || !out_stall;

	// band-pass times level gain once primed, else the input value
	assign band  = $signed({in_res.fast[VAL_W-1], in_res.fast})
		- $signed({in_res.slow[VAL_W-1], in_res.slow});
	assign bprod = band * in_res.gain;
	assign amp   = in_res.primed ? AMP_W'((bprod + 35'sd128) >>> 8)
		: $signed({{(AMP_W-VAL_W){in_res.value[VAL_W-1]}}, in_res.value});

	// chroma attenuation, on chroma samples only
	assign cprod = val_s5 * $signed({1'b0, cfg.chroma_scale});
	assign chr   = chroma_s5 ? CHR_W'((cprod + 44'sd32768) >>> 16)
		: $signed({val_s5[AMP_W-1], val_s5});

	always_comb begin
		if (val_s6 > 28'sd32767) begin
			sat = 16'h7fff;
		end else if (val_s6 < -28'sd32768) begin
			sat = 16'h8000;
		end else begin
			sat = val_s6[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s5    <= in_valid;
			valid_s6    <= valid_s5;
			out_valid_q <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s5    <= amp;
			chroma_s5 <= in_res.chroma;
			addr_s5   <= in_res.addr;
			fend_s5   <= in_res.fend;
			val_s6    <= chr;
			addr_s6   <= addr_s5;
			fend_s6   <= fend_s5;
			amp_q     <= sat;
			addr_q    <= addr_s6;
			fend_q    <= fend_s6;
		end
	end

	assign out_valid       = out_valid_q;
	assign amplified_value = amp_q;
	assign out_addr        = addr_q;
	assign out_frame_end   = fend_q;

	`PTIM_ASSERT_NEXT(a_pipe_hold, valid_s6 && !adv, $stable(val_s6) && $stable(addr_s6), "pipeline moved while held")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import ptim_pkg::*;

	localparam int NUM_LEVELS  = 6;
	localparam int ADDR_SPAN   = 65536;
	localparam int LATENCY     = 7;
	localparam int LONG_HOLD   = 300;
	localparam int RAND_ITEMS  = 180;
	localparam int NUM_SETS    = 6;
	localparam int MAX_REPORTS = 10;
	localparam longint TIMEOUT_NS = 2_000_000;

	localparam logic [CHAN_W-1:0] CHAN_Y     = 2'd0;
	localparam logic [CHAN_W-1:0] CHAN_SPARE = 2'd3;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [ADDR_W-1:0]       addr;
		logic [LVL_W-1:0]        level;
		logic [CHAN_W-1:0]       chan;
		logic                    fend;
	} coef_item_t;

	typedef struct packed {
		coef_item_t              item;
		logic                    fixed;
		logic signed [VAL_W-1:0] fixed_val;
	} stim_row_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [ADDR_W-1:0]       addr;
		logic                    fend;
	} amp_res_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [VAL_W-1:0]     coeff_value;
	logic [ADDR_W-1:0]    coeff_addr;
	logic [LVL_W-1:0]     level_index;
	logic [CHAN_W-1:0]    chan_index;
	logic                 frame_end;
	logic                 out_valid;
	logic                 out_stall;
	logic [VAL_W-1:0]     amplified_value;
	logic [ADDR_W-1:0]    out_addr;
	logic                 out_frame_end;

	pyramid_temporal_iir_magnifier #(
		.LEVELS      (NUM_LEVELS),
		.COEFF_DEPTH (ADDR_SPAN)
	) u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.coeff_value     (coeff_value),
		.coeff_addr      (coeff_addr),
		.level_index     (level_index),
		.chan_index      (chan_index),
		.frame_end       (frame_end),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.amplified_value (amplified_value),
		.out_addr        (out_addr),
		.out_frame_end   (out_frame_end)
	);

	// model state
	longint cfg_alpha     = longint'(ALPHA_RST);
	longint cfg_rate_fast = longint'(RATE_FAST_RST);
	longint cfg_rate_slow = longint'(RATE_SLOW_RST);
	longint cfg_chroma    = longint'(CHROMA_RST);
	longint cfg_lambda    = longint'(LAMBDA_RST);
	logic signed [VAL_W-1:0] fast_lp [0:ADDR_SPAN-1];
	logic signed [VAL_W-1:0] slow_lp [0:ADDR_SPAN-1];
	logic primed = 1'b0;

	amp_res_t amp_expected_q [$];
	logic [ADDR_W-1:0] addr_pool [$];
	logic [ADDR_W-1:0] last_addr = '0;

	logic                    cur_fixed;
	logic signed [VAL_W-1:0] cur_fixed_val;

	int mismatch_count = 0;
	int items_in       = 0;
	int results_out    = 0;
	int sat_count      = 0;
	int settings_used  = 1;
	int hold_requests  = 0;
	int holds_done     = 0;
	int burst_left     = 0;

	stim_row_t prime_rows [7] = '{
		'{'{16'sh7fff, 16'h0000, 3'd1, CHAN_Y,     1'b0}, 1'b1, 16'sh7fff},
		'{'{16'sh8000, 16'hffff, 3'd5, CHAN_Y,     1'b0}, 1'b1, 16'sh8000},
		'{'{16'sh8000, 16'h5555, 3'd0, CHAN_CB,    1'b0}, 1'b1, -16'sd3277},
		'{'{16'sh7fff, 16'haaaa, 3'd6, CHAN_CR,    1'b0}, 1'b1, 16'sd3277},
		'{'{16'shffff, 16'h1234, 3'd3, CHAN_SPARE, 1'b0}, 1'b1, 16'shffff},
		'{'{16'sh0000, 16'h00ff, 3'd7, CHAN_Y,     1'b0}, 1'b1, 16'sh0000},
		'{'{16'sh0100, 16'hff00, 3'd2, CHAN_CB,    1'b0}, 1'b1, 16'sd26}
	};

	stim_row_t band_rows [9] = '{
		'{'{16'sh8000, 16'h0000, 3'd0, CHAN_Y,     1'b0}, 1'b1, 16'sh0000},
		'{'{16'sh7fff, 16'hffff, 3'd6, CHAN_CB,    1'b0}, 1'b1, 16'sh0000},
		'{'{16'sh7fff, 16'h5555, 3'd7, CHAN_SPARE, 1'b0}, 1'b1, 16'sh0000},
		'{'{16'sh8000, 16'haaaa, 3'd1, CHAN_Y,     1'b0}, 1'b0, 16'sh0000},
		'{'{16'sh8000, 16'haaaa, 3'd1, CHAN_Y,     1'b0}, 1'b0, 16'sh0000},
		'{'{16'sd12345, 16'h1234, 3'd2, CHAN_CB,   1'b0}, 1'b0, 16'sh0000},
		'{'{-16'sd20000, 16'h00ff, 3'd3, CHAN_CR,  1'b0}, 1'b0, 16'sh0000},
		'{'{16'sh7fff, 16'hff00, 3'd4, CHAN_SPARE, 1'b0}, 1'b0, 16'sh0000},
		'{'{16'sh7fff, 16'h0000, 3'd5, CHAN_Y,     1'b1}, 1'b0, 16'sh0000}
	};

	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint lowpass_step(longint lp, longint x, longint r);
		return round_shift((65536 - r) * lp + r * x, 16);
	endfunction

	function automatic longint band_gain(logic [LVL_W-1:0] lvl);
		int s;
		longint c;
		if (lvl == 0 || lvl >= NUM_LEVELS) return 0;
		s = NUM_LEVELS - int'(lvl);
		c = (2 * cfg_lambda - (longint'(512) << s)) >>> s;
		return (c > cfg_alpha) ? cfg_alpha : c;
	endfunction

	function automatic amp_res_t predict_amplified(coef_item_t it);
		longint v;
		longint f;
		longint sl;
		amp_res_t r;
		if (!primed) begin
			fast_lp[it.addr] = it.value;
			slow_lp[it.addr] = it.value;
			v = longint'(it.value);
			if (it.fend) primed = 1'b1;
		end else begin
			f = lowpass_step(longint'(fast_lp[it.addr]), longint'(it.value), cfg_rate_fast);
			sl = lowpass_step(longint'(slow_lp[it.addr]), longint'(it.value), cfg_rate_slow);
			fast_lp[it.addr] = f[VAL_W-1:0];
			slow_lp[it.addr] = sl[VAL_W-1:0];
			v = round_shift((f - sl) * band_gain(it.level), 8);
		end
		if (it.chan == CHAN_CB || it.chan == CHAN_CR) v = round_shift(v * cfg_chroma, 16);
		if (v > 32767) begin
			v = 32767;
			sat_count++;
		end else if (v < -32768) begin
			v = -32768;
			sat_count++;
		end
		r.value = v[VAL_W-1:0];
		r.addr = it.addr;
		r.fend = it.fend;
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] random_value();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'shffff;
			4: return VAL_W'($urandom_range(0, 511) - 256);
			default: return VAL_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic coef_item_t random_item();
		coef_item_t it;
		it.value = random_value();
		if ($urandom_range(0, 4) == 0)
			it.addr = last_addr;
		else
			it.addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
		last_addr = it.addr;
		it.level = LVL_W'($urandom_range(0, 7));
		it.chan = CHAN_W'($urandom_range(0, 3));
		it.fend = ($urandom_range(0, 15) == 0);
		return it;
	endfunction

	task automatic note_mismatch(string field, longint want, longint got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch on %s, result %0d at %0t: expected %0d, got %0d",
				field, results_out, $realtime, want, got);
	endtask

	task automatic send_item(coef_item_t it, logic fixed, logic signed [VAL_W-1:0] fixed_val);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 30);
			repeat (gap) begin
				in_valid = 1'b0;
				@(negedge clk);
			end
		end
		burst_left--;
		coeff_value = it.value;
		coeff_addr = it.addr;
		level_index = it.level;
		chan_index = it.chan;
		frame_end = it.fend;
		cur_fixed = fixed;
		cur_fixed_val = fixed_val;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = data;
		@(negedge clk);
	endtask

	task automatic write_config(cfg_t c);
		write_reg(REG_ALPHA, CFG_W'(c.alpha));
		write_reg(REG_RATE_FAST, CFG_W'(c.rate_fast));
		write_reg(REG_RATE_SLOW, CFG_W'(c.rate_slow));
		write_reg(REG_CHROMA, CFG_W'(c.chroma_scale));
		write_reg(REG_LAMBDA, c.lambda_ratio);
		cfg_we = 1'b0;
		settings_used++;
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (amp_expected_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 3) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d results outstanding", amp_expected_q.size());
		$display("Simulation FAILED");
		$finish;
	end

	// receiver back-pressure
	initial begin
		stall_mode_t mode;
		int seg_left;
		mode = STALL_NONE;
		seg_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done < hold_requests) begin
				out_stall = 1'b1;
				for (int c = 0; c < LONG_HOLD; c++) @(negedge clk);
				holds_done++;
			end
			if (seg_left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				seg_left = $urandom_range(10, 150);
			end
			seg_left--;
			case (mode)
				STALL_NONE:  out_stall = 1'b0;
				STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
				default:     out_stall = ~out_stall;
			endcase
		end
	end

	always @(posedge clk) begin
		amp_res_t want;
		coef_item_t seen;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_ALPHA:     cfg_alpha = longint'(cfg_data[PAR_W-1:0]);
					REG_RATE_FAST: cfg_rate_fast = longint'(cfg_data[PAR_W-1:0]);
					REG_RATE_SLOW: cfg_rate_slow = longint'(cfg_data[PAR_W-1:0]);
					REG_CHROMA:    cfg_chroma = longint'(cfg_data[PAR_W-1:0]);
					REG_LAMBDA:    cfg_lambda = longint'(cfg_data[LAM_W-1:0]);
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				seen = '{coeff_value, coeff_addr, level_index, chan_index, frame_end};
				want = predict_amplified(seen);
				if (cur_fixed) want.value = cur_fixed_val;
				amp_expected_q = {amp_expected_q, want};
				items_in++;
			end
			if (out_valid && !out_stall) begin
				if (amp_expected_q.size() == 0) begin
					note_mismatch("unexpected transfer", 0,
						longint'($signed(amplified_value)));
				end else begin
					want = amp_expected_q.pop_front();
					if (amplified_value !== want.value)
						note_mismatch("amplified_value", longint'(want.value),
							longint'($signed(amplified_value)));
					if (out_addr !== want.addr)
						note_mismatch("out_addr", longint'(want.addr), longint'(out_addr));
					if (out_frame_end !== want.fend)
						note_mismatch("out_frame_end", longint'(want.fend),
							longint'(out_frame_end));
				end
				results_out++;
			end
		end
	end

	initial begin
		cfg_t cset;
		coef_item_t it;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_ALPHA;
		cfg_data = '0;
		in_valid = 1'b0;
		coeff_value = '0;
		coeff_addr = '0;
		level_index = '0;
		chan_index = '0;
		frame_end = 1'b0;
		cur_fixed = 1'b0;
		cur_fixed_val = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// first frame loads the filters with reset settings
		foreach (prime_rows[r]) begin
			addr_pool = {addr_pool, prime_rows[r].item.addr};
			send_item(prime_rows[r].item, prime_rows[r].fixed, prime_rows[r].fixed_val);
		end
		for (int i = 0; i < 48; i++) begin
			it.value = random_value();
			it.addr = ADDR_W'($urandom_range(0, ADDR_SPAN - 1));
			it.level = LVL_W'($urandom_range(0, 7));
			it.chan = CHAN_W'($urandom_range(0, 3));
			it.fend = (i == 47);
			addr_pool = {addr_pool, it.addr};
			send_item(it, 1'b0, '0);
		end
		foreach (band_rows[r])
			send_item(band_rows[r].item, band_rows[r].fixed, band_rows[r].fixed_val);
		drain();

		for (int k = 0; k < NUM_SETS; k++) begin
			case (k)
				0: cset = '{16'hffff, 16'hffff, 16'h0000, 16'hffff, 24'hffffff};
				1: cset = '{16'h0000, 16'h0000, 16'hffff, 16'h0000, 24'h000000};
				2: cset = '{ALPHA_RST, RATE_FAST_RST, RATE_SLOW_RST, CHROMA_RST, 24'h000c00};
				default: begin
					cset.alpha = PAR_W'($urandom_range(0, 65535) >> $urandom_range(0, 8));
					cset.rate_fast = PAR_W'($urandom_range(0, 65535));
					cset.rate_slow = PAR_W'($urandom_range(0, 65535) >> $urandom_range(0, 4));
					cset.chroma_scale = PAR_W'($urandom_range(0, 65535));
					cset.lambda_ratio = LAM_W'($urandom_range(0, 24'hffffff)
						>> $urandom_range(0, 16));
				end
			endcase
			write_config(cset);
			for (int i = 0; i < RAND_ITEMS; i++) begin
				if ((k == 1 || k == 4) && i == 40) hold_requests++;
				send_item(random_item(), 1'b0, '0);
			end
			drain();
		end

		$display("covered %0d coefficient transfers in, %0d results out, %0d register settings",
			items_in, results_out, settings_used);
		$display("%0d results saturated, %0d long receiver hold-offs", sat_count, holds_done);
		if (mismatch_count == 0 && amp_expected_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: pyramid_temporal_iir_magnifier.f
+incdir+rtl/core
rtl/core/ptim_pkg.sv
rtl/core/ptim_ram.sv
rtl/core/ptim_index.sv
rtl/core/ptim_lowpass.sv
rtl/core/ptim_scale.sv
rtl/core/pyramid_temporal_iir_magnifier.sv
tb/tb_top.sv
